/* design/periodic_sample_folding_averager_assert.svh */
// assertion macros used by psfa_back of the averager rtl
`ifndef PERIODIC_SAMPLE_FOLDING_AVERAGER_ASSERT_SVH
`define PERIODIC_SAMPLE_FOLDING_AVERAGER_ASSERT_SVH

// same-cycle implication, checked on clk, off while arst_n is low
`define PSFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PSFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/psfa_pkg.sv */
// ----------------------------------------------------------------------------
// psfa_pkg
// Types, constants and helpers of the periodic sample folding averager.
// ----------------------------------------------------------------------------
`default_nettype none

package psfa_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 16;
	localparam int SUM_BITS    = 32;
	localparam int PERIOD_BITS = 11;
	localparam int INDEX_BITS  = 10;
	localparam int MAG_BITS    = 16;

	localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(1024);
	localparam logic [COUNT_BITS-1:0]  COUNT_FULL   = '1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_i;
		logic signed [SAMPLE_BITS-1:0] sample_q;
	} sample_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] bin_index;
		logic [MAG_BITS-1:0]   mean_magnitude;
		logic                  bin_saturated;
	} result_t;

	typedef struct packed {
		logic signed [SUM_BITS-1:0] sum_i;
		logic signed [SUM_BITS-1:0] sum_q;
		logic [COUNT_BITS-1:0]      count;
	} bin_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_UPD,
		BK_MULI,
		BK_MULQ,
		BK_ADD,
		BK_MAG,
		BK_OUT
	} back_state_t;

	typedef enum logic [1:0] {
		MG_IDLE,
		MG_SQRT,
		MG_DIV
	} mag_state_t;

	// clamp a one-bit-wider sum to the signed sum range
	function automatic logic signed [SUM_BITS-1:0] sat_sum(input logic signed [SUM_BITS:0] s);
		logic signed [SUM_BITS-1:0] r;
		if (s[SUM_BITS] != s[SUM_BITS-1]) begin
			r = s[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
		end else begin
			r = s[SUM_BITS-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/psfa_ram.sv */
// ----------------------------------------------------------------------------
// psfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* design/psfa_queue.sv */
// ----------------------------------------------------------------------------
// psfa_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module psfa_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	output logic                  head_valid,
	output logic      [WIDTH-1:0] head_data,
	input  wire logic             pop
);

	logic [WIDTH-1:0] buf_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= push_data;
		end
	end

	assign full       = cnt_q[1];
	assign head_valid = (cnt_q != 2'd0);
	assign head_data  = buf_q[rd_q];

endmodule

`default_nettype wire

/* design/psfa_mag.sv */
// ----------------------------------------------------------------------------
// psfa_mag
// Iterative magnitude unit: floor square root, then floor divide by count.
// ----------------------------------------------------------------------------
`default_nettype none

module psfa_mag
	import psfa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  abort,
	input  wire logic                  start,
	input  wire logic [2*SUM_BITS-1:0] energy,
	input  wire logic [COUNT_BITS-1:0] divisor,
	output logic                       done,
	output logic      [MAG_BITS-1:0]   mag
);

	localparam int RW = SUM_BITS;
	localparam int SW = $clog2(RW);

	mag_state_t state_q, state_d;

	logic [2*RW-1:0]     x_q;
	logic [RW+1:0]       rem_q;
	logic [RW-1:0]       root_q;
	logic [COUNT_BITS:0] drem_q;
	logic [COUNT_BITS-1:0] div_q;
	logic [SW-1:0]       step_q;
	logic                done_q;
	logic [MAG_BITS-1:0] mag_q;

	logic [RW+1:0]       rem_n;
	logic [RW+1:0]       trial;
	logic [COUNT_BITS:0] drem_n;
	logic                last;

	assign rem_n  = {rem_q[RW-1:0], x_q[2*RW-1:2*RW-2]};
	assign trial  = {root_q, 2'b01};
	assign drem_n = {drem_q[COUNT_BITS-1:0], root_q[RW-1]};
	assign last   = (step_q == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MG_IDLE: if (start) state_d = MG_SQRT;
			MG_SQRT: if (last) state_d = MG_DIV;
			MG_DIV:  if (last) state_d = MG_IDLE;
			default: state_d = MG_IDLE;
		endcase
		if (abort) state_d = MG_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MG_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == MG_DIV) && last && !abort;
		end
	end

	// root register is reused as the dividend/quotient during the divide
	always_ff @(posedge clk) begin
		case (state_q)
			MG_IDLE: begin
				x_q    <= energy;
				div_q  <= divisor;
				rem_q  <= '0;
				root_q <= '0;
				step_q <= SW'(RW-1);
			end
			MG_SQRT: begin
				x_q <= {x_q[2*RW-3:0], 2'b00};
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[RW-2:0], 1'b0};
				end
				step_q <= last ? SW'(RW-1) : step_q - 1'b1;
				drem_q <= '0;
			end
			MG_DIV: begin
				if (drem_n >= {1'b0, div_q}) begin
					drem_q <= drem_n - {1'b0, div_q};
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					drem_q <= drem_n;
					root_q <= {root_q[RW-2:0], 1'b0};
				end
				step_q <= step_q - 1'b1;
				if (last) begin
					mag_q <= (root_q[RW-2:MAG_BITS-1] != '0) ? '1
						: {root_q[MAG_BITS-2:0], drem_n >= {1'b0, div_q}};
				end
			end
			default: begin
				step_q <= SW'(RW-1);
			end
		endcase
	end

	assign done = done_q;
	assign mag  = mag_q;

endmodule

`default_nettype wire

/* design/psfa_front.sv */
// ----------------------------------------------------------------------------
// psfa_front
// Takes samples, holds the period register, assigns each sample its bin.
// ----------------------------------------------------------------------------
`default_nettype none

module psfa_front
	import psfa_pkg::*;
#(
	parameter int MAX_BINS = 1024,
	parameter int PW       = $clog2(MAX_BINS)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   period_we,
	input  wire logic [PERIOD_BITS-1:0] period_wdata,
	input  wire logic                   sample_valid,
	output logic                        sample_stall,
	input  wire sample_t                sample,
	input  wire back_status_t           status,
	output logic                        q_push,
	output logic [PW+$bits(sample_t)-1:0] q_data,
	input  wire logic                   q_full
);

	localparam int LW = (PW + 1 > PERIOD_BITS) ? PW + 1 : PERIOD_BITS;

	logic [PERIOD_BITS-1:0] period_q;
	logic [PW-1:0]          pos_q;
	logic [LW-1:0]          per_raw;
	logic [LW-1:0]          per_eff;
	logic [PW-1:0]          pos_use;
	logic [LW-1:0]          pos_inc;

	always_comb begin
		per_raw = LW'(period_q);
		per_eff = per_raw;
		if (per_raw == '0) per_eff = LW'(1);
		if (per_raw > LW'(MAX_BINS)) per_eff = LW'(MAX_BINS);
		pos_use = (LW'(pos_q) >= per_eff) ? '0 : pos_q;
		pos_inc = LW'(pos_use) + LW'(1);
	end

	assign sample_stall = q_full || status.clearing;
	assign q_push       = sample_valid && !sample_stall;
	assign q_data       = {pos_use, sample};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			pos_q    <= '0;
		end else if (period_we) begin
			period_q <= period_wdata;
			pos_q    <= '0;
		end else if (q_push) begin
			pos_q <= (pos_inc >= per_eff) ? '0 : pos_inc[PW-1:0];
		end
	end

endmodule

`default_nettype wire

/* design/psfa_back.sv */
// ----------------------------------------------------------------------------
// psfa_back
// Folds each queued sample into its bin and works out the mean magnitude.
// ----------------------------------------------------------------------------
`default_nettype none
`include "periodic_sample_folding_averager_assert.svh"

module psfa_back
	import psfa_pkg::*;
#(
	parameter int MAX_BINS = 1024,
	parameter int PW       = $clog2(MAX_BINS)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        clr,
	input  wire logic                        q_valid,
	input  wire logic [PW+$bits(sample_t)-1:0] q_data,
	output logic                             q_pop,
	output back_status_t                     status,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output result_t                          result
);

	localparam int SW = $bits(sample_t);

	back_state_t state_q, state_d;

	logic [PW-1:0]   clr_q;
	logic [PW-1:0]   pos_s1;
	sample_t         smp_s1;
	logic signed [SUM_BITS-1:0] sum_i_q;
	logic signed [SUM_BITS-1:0] sum_q_q;
	logic [COUNT_BITS-1:0]      cnt_q;
	logic            sat_q;
	logic [2*SUM_BITS-1:0] sqi_q;
	logic [2*SUM_BITS-1:0] sqq_q;
	logic [MAG_BITS-1:0]   mag_q;
	logic            result_valid_q;
	result_t         result_q;

	logic            ram_we;
	logic [PW-1:0]   ram_waddr;
	bin_t            ram_wdata;
	bin_t            ram_rdata;
	bin_t            upd_bin;
	logic            full;
	logic            mag_start;
	logic            mag_done;
	logic [MAG_BITS-1:0] mag_res;
	logic            load_out;
	logic [SUM_BITS-1:0] abs_i;
	logic [SUM_BITS-1:0] abs_q;
	logic [PW-1:0]   head_pos;

	assign head_pos = q_data[PW+SW-1:SW];

	psfa_ram #(
		.WIDTH ($bits(bin_t)),
		.DEPTH (MAX_BINS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head_pos),
		.rdata (ram_rdata)
	);

	psfa_mag u_mag (
		.clk     (clk),
		.arst_n  (arst_n),
		.abort   (clr),
		.start   (mag_start),
		.energy  (sqi_q + sqq_q),
		.divisor (cnt_q),
		.done    (mag_done),
		.mag     (mag_res)
	);

	always_comb begin
		full          = (ram_rdata.count == COUNT_FULL);
		upd_bin.sum_i = sat_sum({ram_rdata.sum_i[SUM_BITS-1], ram_rdata.sum_i}
			+ (SUM_BITS+1)'(smp_s1.sample_i));
		upd_bin.sum_q = sat_sum({ram_rdata.sum_q[SUM_BITS-1], ram_rdata.sum_q}
			+ (SUM_BITS+1)'(smp_s1.sample_q));
		upd_bin.count = ram_rdata.count + 1'b1;
		if (full) upd_bin = ram_rdata;
		abs_i = sum_i_q[SUM_BITS-1] ? SUM_BITS'(-sum_i_q) : SUM_BITS'(sum_i_q);
		abs_q = sum_q_q[SUM_BITS-1] ? SUM_BITS'(-sum_q_q) : SUM_BITS'(sum_q_q);
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = pos_s1;
		ram_wdata = upd_bin;
		mag_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == PW'(MAX_BINS - 1)) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = BK_UPD;
				end
			end
			BK_UPD: begin
				ram_we  = 1'b1;
				state_d = BK_MULI;
			end
			BK_MULI: state_d = BK_MULQ;
			BK_MULQ: state_d = BK_ADD;
			BK_ADD: begin
				mag_start = 1'b1;
				state_d   = BK_MAG;
			end
			BK_MAG: if (mag_done) state_d = BK_OUT;
			BK_OUT: begin
				if (!result_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
		if (clr) state_d = BK_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= BK_CLEAR;
			clr_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr) clr_q <= '0;
			else if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
			if (load_out) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pos_s1 <= head_pos;
			smp_s1 <= sample_t'(q_data[SW-1:0]);
		end
		if (state_q == BK_UPD) begin
			sum_i_q <= upd_bin.sum_i;
			sum_q_q <= upd_bin.sum_q;
			cnt_q   <= upd_bin.count;
			sat_q   <= full;
		end
		if (state_q == BK_MULI) sqi_q <= abs_i * abs_i;
		if (state_q == BK_MULQ) sqq_q <= abs_q * abs_q;
		if (mag_done) mag_q <= mag_res;
		if (load_out) begin
			result_q.bin_index      <= INDEX_BITS'(pos_s1);
			result_q.mean_magnitude <= (cnt_q == '0) ? '0 : mag_q;
			result_q.bin_saturated  <= sat_q;
		end
	end

	assign status.clearing = (state_q == BK_CLEAR);
	assign result_valid    = result_valid_q;
	assign result          = result_q;

	`PSFA_ASSERT_IMP(a_store_write_owner, ram_we, (state_q == BK_CLEAR || state_q == BK_UPD), "store written outside clear or update")
	`PSFA_ASSERT_IMP(a_mag_done_when_waiting, mag_done, (state_q == BK_MAG), "magnitude finished while back not waiting")
	`PSFA_ASSERT_NXT(a_update_then_square, (state_q == BK_UPD), (state_q == BK_MULI || state_q == BK_CLEAR), "update not followed by squaring")

endmodule

`default_nettype wire

/* design/periodic_sample_folding_averager.sv */
// ----------------------------------------------------------------------------
// periodic_sample_folding_averager
// Folds complex samples into a one-period bin store and reports mean magnitude.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  sample    sample_valid, sample_stall, sample        in
//  result    result_valid, result_stall, result        out
//  period    period_we, period_wdata                   in
//
//  in the back each item goes through a store read-modify-write,
//  two squarings, then a 32-step square root and a 32-step divide in psfa_mag.
//  the front queues up to two items while the back works.
//  after reset and after every period write the store is cleared bin by
//  bin; sample_stall stays high meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_sample_folding_averager
	import psfa_pkg::*;
#(
	parameter int MAX_BINS = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   period_we,
	input  wire logic [PERIOD_BITS-1:0] period_wdata,
	input  wire logic                   sample_valid,
	output logic                        sample_stall,
	input  wire sample_t                sample,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output result_t                     result
);

	localparam int PW = $clog2(MAX_BINS);
	localparam int QW = PW + $bits(sample_t);

	back_status_t  status;
	logic          q_push;
	logic [QW-1:0] q_push_data;
	logic          q_full;
	logic          q_valid;
	logic [QW-1:0] q_head;
	logic          q_pop;

	psfa_front #(
		.MAX_BINS (MAX_BINS),
		.PW       (PW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.period_we    (period_we),
		.period_wdata (period_wdata),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.status       (status),
		.q_push       (q_push),
		.q_data       (q_push_data),
		.q_full       (q_full)
	);

	psfa_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.full       (q_full),
		.head_valid (q_valid),
		.head_data  (q_head),
		.pop        (q_pop)
	);

	psfa_back #(
		.MAX_BINS (MAX_BINS),
		.PW       (PW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.clr          (period_we),
		.q_valid      (q_valid),
		.q_data       (q_head),
		.q_pop        (q_pop),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
